>>> hw/rtl/upd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upd_pkg: shared types and constants of the URL percent decoder.
// Character codes, status codes and the escape state encoding.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;

  localparam logic MODE_PATH  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [ByteW-1:0] CH_NUL     = 8'h00;
  localparam logic [ByteW-1:0] CH_PERCENT = 8'h25;
  localparam logic [ByteW-1:0] CH_PLUS    = 8'h2B;
  localparam logic [ByteW-1:0] CH_SPACE   = 8'h20;
  localparam logic [ByteW-1:0] CH_ZERO    = 8'h30;
  localparam logic [ByteW-1:0] CH_TWO     = 8'h32;
  localparam logic [ByteW-1:0] CH_LOWER_F = 8'h66;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD       = 2'd1,
    ST_FORBIDDEN = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_NORMAL  = 2'd0,
    PH_PERCENT = 2'd1,
    PH_HIGH    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    SL_NONE    = 2'd0,
    SL_PERCENT = 2'd1,
    SL_TWO     = 2'd2
  } slash_e;

  // Bit 4 set: not a hex digit. Otherwise bits 3:0 carry the digit value.
  function automatic logic [4:0] hex_value(input logic [ByteW-1:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/upd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upd_in_if: input channel of the URL percent decoder.
// One raw character of the encoded string per word.
// ----------------------------------------------------------------------------
interface upd_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [upd_pkg::ByteW-1:0] in_byte;
  logic                     is_last;
  logic                     is_empty;

  modport source (output valid, output mode, output in_byte, output is_last,
                  output is_empty, input ready);
  modport sink   (input valid, input mode, input in_byte, input is_last,
                  input is_empty, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/upd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upd_out_if: result channel of the URL percent decoder.
// One decoded character and/or the closing status per word.
// ----------------------------------------------------------------------------
interface upd_out_if;
  logic                        valid;
  logic                        ready;
  logic [upd_pkg::ByteW-1:0]   out_byte;
  logic                        out_valid;
  logic                        end_of_string;
  logic [upd_pkg::StatusW-1:0] status;

  modport source (output valid, output out_byte, output out_valid,
                  output end_of_string, output status, input ready);
  modport sink   (input valid, input out_byte, input out_valid,
                  input end_of_string, input status, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/url_percent_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// url_percent_decoder_unit: streaming percent decoder for one URL component.
// Output: a word's result is registered on accept and sits in the output register in the next cycle.
// Throughput: one word per cycle while the result channel takes each result; a held result stalls input.
// Reset: escape state, error and output valid clear; decoder starts a string.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  upd_in_if.sink      in_i,
  upd_out_if.source   out_o
);

  upd_pkg::phase_e             phase_q, phase_d;
  logic [3:0]                  nib_q, nib_d;
  logic                        zero_q, zero_d;
  upd_pkg::slash_e             slash_q, slash_d;
  upd_pkg::status_e            err_q, err_d;

  logic                        oval_q;
  logic [upd_pkg::ByteW-1:0]   obyte_q, obyte_d;
  logic                        odat_q, odat_d;
  logic                        oend_q, oend_d;
  upd_pkg::status_e            ostat_q, ostat_d;

  logic                        in_acc;
  logic                        produce;
  logic                        have;
  logic                        last;
  logic [upd_pkg::ByteW-1:0]   dat;
  logic [4:0]                  hexv;

  // Output register is free when empty or whenever its word leaves this cycle.
  assign in_i.ready = !oval_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    phase_d = phase_q;
    nib_d   = nib_q;
    zero_d  = zero_q;
    slash_d = slash_q;
    err_d   = err_q;
    have    = 1'b0;
    dat     = upd_pkg::CH_NUL;
    last    = in_i.is_last;
    hexv    = upd_pkg::hex_value(in_i.in_byte);

    if (in_i.is_empty) begin
      if (in_i.mode == upd_pkg::MODE_PATH || phase_q == upd_pkg::PH_PERCENT ||
          phase_q == upd_pkg::PH_HIGH) begin
        err_d = upd_pkg::ST_BAD;
      end
      last = 1'b1;
    end else if (err_q != upd_pkg::ST_BAD) begin
      unique case (phase_q)
        upd_pkg::PH_PERCENT: begin
          if (hexv[4]) begin
            err_d   = upd_pkg::ST_BAD;
            phase_d = upd_pkg::PH_NORMAL;
          end else begin
            nib_d   = hexv[3:0];
            zero_d  = (in_i.in_byte == upd_pkg::CH_ZERO);
            phase_d = upd_pkg::PH_HIGH;
          end
        end
        upd_pkg::PH_HIGH: begin
          phase_d = upd_pkg::PH_NORMAL;
          if (hexv[4]) begin
            err_d = upd_pkg::ST_BAD;
          end else if (in_i.mode == upd_pkg::MODE_PATH && zero_q &&
                       in_i.in_byte == upd_pkg::CH_ZERO) begin
            err_d = upd_pkg::ST_BAD;
          end else begin
            dat = {nib_q, hexv[3:0]};
            if (in_i.mode == upd_pkg::MODE_QUERY && dat == upd_pkg::CH_NUL) begin
              err_d = upd_pkg::ST_BAD;
            end else begin
              have = 1'b1;
            end
          end
        end
        default: begin
          phase_d = upd_pkg::PH_NORMAL;
          if (in_i.in_byte == upd_pkg::CH_PERCENT) begin
            phase_d = upd_pkg::PH_PERCENT;
          end else begin
            dat  = (in_i.mode == upd_pkg::MODE_QUERY && in_i.in_byte == upd_pkg::CH_PLUS)
                   ? upd_pkg::CH_SPACE : in_i.in_byte;
            have = 1'b1;
          end
        end
      endcase

      if (have) begin
        if (in_i.mode == upd_pkg::MODE_PATH) begin
          if (dat == upd_pkg::CH_NUL && err_d == upd_pkg::ST_OK) begin
            err_d = upd_pkg::ST_FORBIDDEN;
          end
          // Track the lowercase decoded text "%2f".
          if (dat == upd_pkg::CH_PERCENT) begin
            slash_d = upd_pkg::SL_PERCENT;
          end else if (slash_q == upd_pkg::SL_PERCENT && dat == upd_pkg::CH_TWO) begin
            slash_d = upd_pkg::SL_TWO;
          end else begin
            if (slash_q == upd_pkg::SL_TWO && dat == upd_pkg::CH_LOWER_F &&
                err_d == upd_pkg::ST_OK) begin
              err_d = upd_pkg::ST_FORBIDDEN;
            end
            slash_d = upd_pkg::SL_NONE;
          end
        end else begin
          slash_d = upd_pkg::SL_NONE;
        end
      end

      if (last && phase_d != upd_pkg::PH_NORMAL) begin
        err_d = upd_pkg::ST_BAD;
      end
    end

    odat_d  = have && err_d == upd_pkg::ST_OK;
    produce = odat_d || last;
    obyte_d = odat_d ? dat : upd_pkg::CH_NUL;
    oend_d  = last;
    ostat_d = last ? err_d : upd_pkg::ST_OK;

    // Close the string: start the next one from a clean state.
    if (last) begin
      phase_d = upd_pkg::PH_NORMAL;
      nib_d   = 4'd0;
      zero_d  = 1'b0;
      slash_d = upd_pkg::SL_NONE;
      err_d   = upd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upd_pkg::PH_NORMAL;
      nib_q   <= 4'd0;
      zero_q  <= 1'b0;
      slash_q <= upd_pkg::SL_NONE;
      err_q   <= upd_pkg::ST_OK;
      oval_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
        nib_q   <= nib_d;
        zero_q  <= zero_d;
        slash_q <= slash_d;
        err_q   <= err_d;
        oval_q  <= produce;
      end else if (out_o.ready) begin
        oval_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      obyte_q <= obyte_d;
      odat_q  <= odat_d;
      oend_q  <= oend_d;
      ostat_q <= ostat_d;
    end
  end

  assign out_o.valid         = oval_q;
  assign out_o.out_byte      = obyte_q;
  assign out_o.out_valid     = odat_q;
  assign out_o.end_of_string = oend_q;
  assign out_o.status        = ostat_q;

`ifndef ASSERT_OFF
  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oval_q && !oend_q |-> ostat_q == upd_pkg::ST_OK)
    else $error("status set on a result that does not close the string");

  a_no_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oval_q |-> odat_q || oend_q)
    else $error("result carries neither data nor end of string");

  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oval_q && !odat_q |-> obyte_q == upd_pkg::CH_NUL)
    else $error("out_byte not zero without data");

  a_clean_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.is_last || in_i.is_empty) |=>
      phase_q == upd_pkg::PH_NORMAL && err_q == upd_pkg::ST_OK &&
      slash_q == upd_pkg::SL_NONE)
    else $error("decoder state not cleared after closing a string");

  a_close_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.is_last || in_i.is_empty) |=> oval_q && oend_q)
    else $error("closing word produced no end-of-string result");
`endif

endmodule
`default_nettype wire

>>> test/url_percent_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_unit_test: self-checking bench for the percent decoder.
// Drives directed and random encoded strings in path and query mode through
// the input channel, predicts each decoded character and closing status, and
// checks the result channel word by word under random idling on both sides.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 300000;

  localparam logic [upd_pkg::ByteW-1:0] CH_NINE    = 8'h39;
  localparam logic [upd_pkg::ByteW-1:0] CH_LOWER_A = 8'h61;
  localparam logic [upd_pkg::ByteW-1:0] CH_UPPER_A = 8'h41;
  localparam logic [upd_pkg::ByteW-1:0] CH_UPPER_F = 8'h46;

  typedef struct {
    logic [upd_pkg::ByteW-1:0] data;
    logic                      data_valid;
    logic                      closes;
    upd_pkg::status_e          status;
  } char_result_t;

  class decode_scoreboard;
    upd_pkg::phase_e  phase;
    logic [3:0]       high_digit;
    logic             high_was_zero;
    upd_pkg::slash_e  slash;
    upd_pkg::status_e verdict;
    char_result_t     pending[$];
    int               errors;
    int               words;
    int               live_words;
    int               checked;
    int               n_ok;
    int               n_bad;
    int               n_forbidden;

    function new();
      clear();
      errors      = 0;
      words       = 0;
      live_words  = 0;
      checked     = 0;
      n_ok        = 0;
      n_bad       = 0;
      n_forbidden = 0;
    endfunction

    function void clear();
      phase         = upd_pkg::PH_NORMAL;
      high_digit    = '0;
      high_was_zero = 1'b0;
      slash         = upd_pkg::SL_NONE;
      verdict       = upd_pkg::ST_OK;
    endfunction

    static function int digit_of(logic [upd_pkg::ByteW-1:0] c);
      if (c >= upd_pkg::CH_ZERO && c <= CH_NINE) return int'(c - upd_pkg::CH_ZERO);
      if (c >= CH_LOWER_A && c <= upd_pkg::CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
      return -1;
    endfunction

    // Predict the result (if any) of one accepted input word.
    function void decode_word(logic mode, logic [upd_pkg::ByteW-1:0] b, logic last,
                              logic empty);
      logic                      have;
      logic [upd_pkg::ByteW-1:0] d;
      int                        h;
      char_result_t              r;
      have = 1'b0;
      d    = '0;
      words++;
      if (empty || verdict != upd_pkg::ST_BAD) live_words++;
      if (empty) begin
        if (mode == upd_pkg::MODE_PATH || phase == upd_pkg::PH_PERCENT ||
            phase == upd_pkg::PH_HIGH) verdict = upd_pkg::ST_BAD;
        last = 1'b1;
      end else if (verdict != upd_pkg::ST_BAD) begin
        h = digit_of(b);
        case (phase)
          upd_pkg::PH_PERCENT: begin
            if (h < 0) begin
              verdict = upd_pkg::ST_BAD;
              phase   = upd_pkg::PH_NORMAL;
            end else begin
              high_digit    = h[3:0];
              high_was_zero = (b == upd_pkg::CH_ZERO);
              phase         = upd_pkg::PH_HIGH;
            end
          end
          upd_pkg::PH_HIGH: begin
            phase = upd_pkg::PH_NORMAL;
            if (h < 0) begin
              verdict = upd_pkg::ST_BAD;
            end else if (mode == upd_pkg::MODE_PATH && high_was_zero &&
                         b == upd_pkg::CH_ZERO) begin
              verdict = upd_pkg::ST_BAD;
            end else begin
              d = {high_digit, h[3:0]};
              if (mode == upd_pkg::MODE_QUERY && d == upd_pkg::CH_NUL) begin
                verdict = upd_pkg::ST_BAD;
              end else begin
                have = 1'b1;
              end
            end
          end
          default: begin
            // Value three of the phase is treated as a normal character.
            phase = upd_pkg::PH_NORMAL;
            if (b == upd_pkg::CH_PERCENT) begin
              phase = upd_pkg::PH_PERCENT;
            end else begin
              d    = (mode == upd_pkg::MODE_QUERY && b == upd_pkg::CH_PLUS)
                     ? upd_pkg::CH_SPACE : b;
              have = 1'b1;
            end
          end
        endcase
        if (have) begin
          if (mode == upd_pkg::MODE_PATH) begin
            if (d == upd_pkg::CH_NUL && verdict == upd_pkg::ST_OK) begin
              verdict = upd_pkg::ST_FORBIDDEN;
            end
            if (d == upd_pkg::CH_PERCENT) begin
              slash = upd_pkg::SL_PERCENT;
            end else if (slash == upd_pkg::SL_PERCENT && d == upd_pkg::CH_TWO) begin
              slash = upd_pkg::SL_TWO;
            end else begin
              if (slash == upd_pkg::SL_TWO && d == upd_pkg::CH_LOWER_F &&
                  verdict == upd_pkg::ST_OK) verdict = upd_pkg::ST_FORBIDDEN;
              slash = upd_pkg::SL_NONE;
            end
          end else begin
            slash = upd_pkg::SL_NONE;
          end
        end
        if (last && phase != upd_pkg::PH_NORMAL) verdict = upd_pkg::ST_BAD;
      end
      have = have && verdict == upd_pkg::ST_OK;
      if (!have && !last) return;
      r.data       = have ? d : '0;
      r.data_valid = have;
      r.closes     = last;
      r.status     = last ? verdict : upd_pkg::ST_OK;
      pending.insert(pending.size(), r);
      if (last) begin
        case (verdict)
          upd_pkg::ST_OK:  n_ok++;
          upd_pkg::ST_BAD: n_bad++;
          default:         n_forbidden++;
        endcase
        clear();
      end
    endfunction

    function void check_result(logic [upd_pkg::ByteW-1:0] ob, logic ov, logic eos,
                               logic [upd_pkg::StatusW-1:0] st);
      char_result_t e;
      if (pending.size() == 0) begin
        $error({"result with nothing expected: out_byte %02h out_valid %0b ",
                "end_of_string %0b status %0d"}, ob, ov, eos, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (ob !== e.data) begin
        $error("out_byte: expected %02h, got %02h", e.data, ob);
        errors++;
      end
      if (ov !== e.data_valid) begin
        $error("out_valid: expected %0b, got %0b", e.data_valid, ov);
        errors++;
      end
      if (eos !== e.closes) begin
        $error("end_of_string: expected %0b, got %0b", e.closes, eos);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   send_idle;
  int   recv_idle;
  int   cycles;

  decode_scoreboard sb = new();

  upd_in_if  in_ch ();
  upd_out_if out_ch ();

  url_percent_decoder_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.pending.size());
      $display("** url_percent_decoder_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Note the accepted word first, so a result cannot overtake its prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.decode_word(in_ch.mode, in_ch.in_byte, in_ch.is_last, in_ch.is_empty);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.out_byte, out_ch.out_valid, out_ch.end_of_string,
                        out_ch.status);
      end
    end
  end

  task automatic send_word(input logic mode, input logic [upd_pkg::ByteW-1:0] b,
                           input logic last, input logic empty);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.in_byte  <= b;
    in_ch.is_last  <= last;
    in_ch.is_empty <= empty;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_text(input logic mode, input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(mode, s[i], i == s.len() - 1, 1'b0);
    end
  endtask

  function automatic logic [upd_pkg::ByteW-1:0] hex_char(input int v);
    if (v < 10) return upd_pkg::CH_ZERO + upd_pkg::ByteW'(v);
    return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + upd_pkg::ByteW'(v - 10);
  endfunction

  function automatic logic [upd_pkg::ByteW-1:0] non_hex_char();
    logic [upd_pkg::ByteW-1:0] c;
    do c = upd_pkg::ByteW'($urandom_range(255));
    while (decode_scoreboard::digit_of(c) >= 0);
    return c;
  endfunction

  // Append one encoded token, mostly well formed, sometimes broken.
  function automatic void add_token(ref logic [upd_pkg::ByteW-1:0] q[$]);
    logic [upd_pkg::ByteW-1:0] c;
    case ($urandom_range(15))
      0, 1, 2, 3, 4, 5: begin
        do c = upd_pkg::ByteW'($urandom_range(32, 126)); while (c == upd_pkg::CH_PERCENT);
        q.insert(q.size(), c);
      end
      6: q.insert(q.size(), upd_pkg::CH_PLUS);
      7, 8: begin
        q.insert(q.size(), upd_pkg::CH_PERCENT);
        q.insert(q.size(), hex_char($urandom_range(15)));
        q.insert(q.size(), hex_char($urandom_range(15)));
      end
      9: begin
        // decoded percent, then the rest of a decoded "%2f" in various spellings
        q.insert(q.size(), upd_pkg::CH_PERCENT);
        q.insert(q.size(), upd_pkg::CH_TWO);
        q.insert(q.size(), hex_char(5));
        case ($urandom_range(2))
          0: begin
            q.insert(q.size(), upd_pkg::CH_TWO);
            q.insert(q.size(), hex_char(15));
          end
          1: begin
            q.insert(q.size(), upd_pkg::CH_PERCENT);
            q.insert(q.size(), hex_char(3));
            q.insert(q.size(), upd_pkg::CH_TWO);
            q.insert(q.size(), upd_pkg::CH_PERCENT);
            q.insert(q.size(), hex_char(6));
            q.insert(q.size(), hex_char(6));
          end
          default: q.insert(q.size(), upd_pkg::CH_TWO);
        endcase
      end
      10: begin
        q.insert(q.size(), upd_pkg::CH_PERCENT);
        q.insert(q.size(), upd_pkg::CH_ZERO);
        q.insert(q.size(), hex_char($urandom_range(3) == 0 ? 0 : $urandom_range(15)));
      end
      11: begin
        q.insert(q.size(), upd_pkg::CH_PERCENT);
        if ($urandom_range(1)) q.insert(q.size(), hex_char($urandom_range(15)));
        q.insert(q.size(), non_hex_char());
      end
      12: q.insert(q.size(), upd_pkg::CH_NUL);
      13: q.insert(q.size(), upd_pkg::ByteW'($urandom_range(255)));
      14: q.insert(q.size(), upd_pkg::CH_PERCENT);
      default: begin
        q.insert(q.size(), upd_pkg::CH_PERCENT);
        q.insert(q.size(), upd_pkg::CH_TWO);
        q.insert(q.size(), hex_char(15));
      end
    endcase
  endfunction

  task automatic send_random_string();
    logic [upd_pkg::ByteW-1:0] chars[$];
    logic                      mode;
    logic                      mixed;
    logic                      close_empty;
    int                        want;
    if ($urandom_range(11) == 0) begin
      send_word(1'($urandom_range(1)), upd_pkg::ByteW'($urandom_range(255)),
                1'($urandom_range(1)), 1'b1);
      return;
    end
    mode        = 1'($urandom_range(1));
    mixed       = ($urandom_range(7) == 0);
    close_empty = ($urandom_range(15) == 0);
    want        = $urandom_range(1, 10);
    while (chars.size() < want) add_token(chars);
    foreach (chars[i]) begin
      send_word(mixed ? logic'($urandom_range(1)) : mode, chars[i],
                !close_empty && i == chars.size() - 1, 1'b0);
    end
    // Close with the empty marker instead of a last byte.
    if (close_empty) send_word(mode, upd_pkg::ByteW'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin
    rst_ni          = 1'b0;
    send_idle       = 35;
    recv_idle       = 88;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= upd_pkg::MODE_PATH;
    in_ch.in_byte  <= '0;
    in_ch.is_last  <= 1'b0;
    in_ch.is_empty <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text(upd_pkg::MODE_PATH, "a");
    send_text(upd_pkg::MODE_QUERY, "+");
    send_text(upd_pkg::MODE_PATH, "%4a");
    send_text(upd_pkg::MODE_QUERY, "%FF");
    send_word(upd_pkg::MODE_PATH, 8'hA5, 1'b0, 1'b1);
    send_word(upd_pkg::MODE_QUERY, 8'h5A, 1'b1, 1'b1);
    send_text(upd_pkg::MODE_PATH, "%00");
    send_text(upd_pkg::MODE_PATH, "%252f");
    send_word(upd_pkg::MODE_QUERY, upd_pkg::CH_NUL, 1'b1, 1'b0);
    send_text(upd_pkg::MODE_PATH, "%2");
    send_text(upd_pkg::MODE_QUERY, "%gx");
    send_word(upd_pkg::MODE_PATH, 8'hFF, 1'b1, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 35;
          recv_idle = 88;
        end
        1: begin
          send_idle = 88;
          recv_idle = 35;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      while (sb.words < (ph + 1) * 200) send_random_string();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("sent %0d words (%0d decoded), checked %0d results", sb.words, sb.live_words,
             sb.checked);
    $display("closed strings: %0d ok, %0d bad request, %0d forbidden", sb.n_ok, sb.n_bad,
             sb.n_forbidden);
    if (sb.errors == 0) begin
      $display("** url_percent_decoder_unit: PASSED **");
    end else begin
      $display("** url_percent_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/upd_pkg.sv
hw/rtl/upd_in_if.sv
hw/rtl/upd_out_if.sv
hw/rtl/url_percent_decoder_unit.sv
test/url_percent_decoder_unit_test.sv
